// ----- sv/grm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the grid rectangle merger.
package grm_pkg;

   // Request word: one cell load or one rectangle read.
   typedef struct packed {
      logic action;
      logic solid;
   } req_type;

   // Response word: one merged rectangle in tile units.
   typedef struct packed {
      logic [5:0] rect_x;
      logic [5:0] rect_y;
      logic [6:0] rect_w;
      logic [6:0] rect_h;
      logic       last_rect;
      logic       empty_set;
   } rsp_type;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'b1;
   localparam logic [CSR_DATA_W-1:0] GRID_DIM_RESET = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD,
      ST_I_RD,
      ST_I_EV,
      ST_J_RD,
      ST_J_EV,
      ST_I_WB,
      ST_C_RD,
      ST_C_EV,
      ST_OUT_RD,
      ST_OUT_EV
   } state_type;

endpackage

// ----- sv/grm_fuse_unit.sv -----
`timescale 1ns / 1ps
// Shared edge-compare and extent-add unit used by both fuse passes.
module grm_fuse_unit #(
   parameter int XW = 6,
   parameter int YW = 6,
   parameter int WW = 7,
   parameter int HW = 7
) (
   input  logic          vertical,
   input  logic [XW-1:0] base_x,
   input  logic [YW-1:0] base_y,
   input  logic [WW-1:0] base_w,
   input  logic [HW-1:0] base_h,
   input  logic [XW-1:0] cand_x,
   input  logic [YW-1:0] cand_y,
   input  logic [WW-1:0] cand_w,
   input  logic [HW-1:0] cand_h,
   output logic          hit,
   output logic [WW-1:0] grown_w,
   output logic [HW-1:0] grown_h
);

   logic [WW:0] right_edge;
   logic [HW:0] bottom_edge;
   logic        hit_h;
   logic        hit_v;

   assign right_edge  = (WW+1)'(base_x) + (WW+1)'(base_w);
   assign bottom_edge = (HW+1)'(base_y) + (HW+1)'(base_h);

   assign hit_h = (base_y == cand_y) && (base_h == cand_h) &&
                  (right_edge == (WW+1)'(cand_x));
   assign hit_v = (base_x == cand_x) && (base_w == cand_w) &&
                  (bottom_edge == (HW+1)'(cand_y));

   always_comb begin
      hit     = vertical ? hit_v : hit_h;
      grown_w = vertical ? base_w : WW'(base_w + cand_w);
      grown_h = vertical ? HW'(base_h + cand_h) : base_h;
   end

endmodule

// ----- sv/grm_rect_mem.sv -----
`timescale 1ns / 1ps
// Rectangle store: one write port, one registered read port.
module grm_rect_mem #(
   parameter int DEPTH  = 4096,
   parameter int DATA_W = 27
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/grm_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: cell loading, position divide, fuse passes, compaction and readout.
module grm_ctrl #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  grm_pkg::req_type                    req,
   output logic                                busy,
   input  logic [$clog2(MAX_COLS+1)-1:0]       cols,
   input  logic [$clog2(MAX_ROWS+1)-1:0]       rows,
   input  logic                                cfg_wr,
   output logic                                rsp_strobe,
   output grm_pkg::rsp_type                    rsp,
   output logic                                mem_we,
   output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] mem_waddr,
   output logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)+$clog2(MAX_COLS+1)
                 +$clog2(MAX_ROWS+1):0]        mem_wdata,
   output logic                                mem_re,
   output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] mem_raddr,
   input  logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)+$clog2(MAX_COLS+1)
                 +$clog2(MAX_ROWS+1):0]        mem_rdata
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int NW    = CW + 1;
   localparam int XW    = $clog2(MAX_COLS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int WW    = $clog2(MAX_COLS + 1);
   localparam int HW    = $clog2(MAX_ROWS + 1);
   localparam int CLW   = $clog2(MAX_COLS + 1);
   localparam int DCW   = $clog2(CW + 1);

   typedef struct packed {
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [WW-1:0] w;
      logic [HW-1:0] h;
      logic          live;
   } rect_type;

   grm_pkg::state_type state_ff, state_in;
   logic               vert_ff, vert_in;
   logic               fused_ff, fused_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      rc_ff, rc_in;
   logic [CW-1:0]      rp_ff, rp_in;
   logic [CW-1:0]      cell_ff, cell_in;
   logic [XW-1:0]      cx_ff, cx_in;
   logic [CW-1:0]      cy_ff, cy_in;
   logic               dirty_ff, dirty_in;
   logic               md_ff, md_in;
   rect_type           base_ff, base_in;
   logic [CLW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]      quo_ff, quo_in;
   logic [DCW-1:0]     dcnt_ff, dcnt_in;
   logic               solid_ff, solid_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   grm_pkg::rsp_type   rsp_ff, rsp_in;

   rect_type           rd;
   rect_type           wr;
   logic               fu_hit;
   logic [WW-1:0]      fu_w;
   logic [HW-1:0]      fu_h;

   // load path operands
   logic               fresh;
   logic [XW-1:0]      ld_x;
   logic [CW-1:0]      ld_y;
   logic [CW-1:0]      ld_cell;
   logic [CW-1:0]      ld_rc;
   logic               ld_solid;
   logic               in_grid;

   // divide step
   logic [CLW:0]       trial;
   logic               q_bit;
   logic [CLW-1:0]     rem_new;
   logic [CW-1:0]      quo_new;

   logic               i_more;
   logic               j_more;
   logic               c_more;
   logic [CW-1:0]      k_next;

   assign rd        = rect_type'(mem_rdata);
   assign mem_wdata = wr;

   grm_fuse_unit #(
      .XW(XW),
      .YW(YW),
      .WW(WW),
      .HW(HW)
   ) u_fuse (
      .vertical (vert_ff),
      .base_x   (base_ff.x),
      .base_y   (base_ff.y),
      .base_w   (base_ff.w),
      .base_h   (base_ff.h),
      .cand_x   (rd.x),
      .cand_y   (rd.y),
      .cand_w   (rd.w),
      .cand_h   (rd.h),
      .hit      (fu_hit),
      .grown_w  (fu_w),
      .grown_h  (fu_h)
   );

   always_comb begin
      fresh    = (state_ff == grm_pkg::ST_IDLE) && md_ff;
      ld_x     = fresh ? '0 : cx_ff;
      ld_y     = fresh ? '0 : cy_ff;
      ld_cell  = fresh ? '0 : cell_ff;
      ld_rc    = fresh ? '0 : rc_ff;
      ld_solid = (state_ff == grm_pkg::ST_IDLE) ? req.solid : solid_ff;
      in_grid  = ld_y < CW'(rows);

      trial    = {rem_ff, quo_ff[CW-1]};
      q_bit    = trial >= (CLW+1)'(cols);
      rem_new  = q_bit ? CLW'(trial - (CLW+1)'(cols)) : CLW'(trial);
      quo_new  = {quo_ff[CW-2:0], q_bit};

      i_more   = (NW'(i_ff) + NW'(2)) < NW'(rc_ff);
      j_more   = (NW'(j_ff) + NW'(1)) < NW'(rc_ff);
      c_more   = (NW'(i_ff) + NW'(1)) < NW'(rc_ff);
      k_next   = k_ff + CW'(rd.live);
   end

   always_comb begin
      state_in      = state_ff;
      vert_in       = vert_ff;
      fused_in      = fused_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      rc_in         = rc_ff;
      rp_in         = rp_ff;
      cell_in       = cell_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      dirty_in      = dirty_ff;
      md_in         = md_ff;
      base_in       = base_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      solid_in      = solid_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = i_ff[AW-1:0];
      wr            = base_ff;
      mem_re        = 1'b0;
      mem_raddr     = i_ff[AW-1:0];

      unique case (state_ff)
         grm_pkg::ST_IDLE: begin
            if (start) begin
               if (req.action == grm_pkg::ACT_READ) begin
                  if (md_ff) begin
                     state_in = grm_pkg::ST_OUT_RD;
                  end else if (rc_ff > CW'(1)) begin
                     vert_in  = 1'b0;
                     fused_in = 1'b0;
                     i_in     = '0;
                     state_in = grm_pkg::ST_I_RD;
                  end else begin
                     md_in    = 1'b1;
                     rp_in    = '0;
                     state_in = grm_pkg::ST_OUT_RD;
                  end
               end else if (!md_ff && dirty_ff) begin
                  // grid shape changed: recover column and row from cell count
                  solid_in = req.solid;
                  rem_in   = '0;
                  quo_in   = cell_ff;
                  dcnt_in  = '0;
                  state_in = grm_pkg::ST_DIV;
               end else begin
                  md_in    = 1'b0;
                  dirty_in = 1'b0;
                  cell_in  = ld_cell;
                  cx_in    = ld_x;
                  cy_in    = ld_y;
                  rc_in    = ld_rc;
                  if (md_ff) begin
                     rp_in = '0;
                  end
                  if (in_grid) begin
                     cell_in = ld_cell + CW'(1);
                     if (CLW'(ld_x) + CLW'(1) == cols) begin
                        cx_in = '0;
                        cy_in = ld_y + CW'(1);
                     end else begin
                        cx_in = XW'(ld_x + XW'(1));
                     end
                     if (ld_solid) begin
                        mem_we    = 1'b1;
                        mem_waddr = ld_rc[AW-1:0];
                        wr        = '{x: ld_x, y: YW'(ld_y), w: WW'(1), h: HW'(1),
                                      live: 1'b1};
                        rc_in     = ld_rc + CW'(1);
                     end
                  end
               end
            end
         end

         grm_pkg::ST_DIV: begin
            rem_in  = rem_new;
            quo_in  = quo_new;
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(CW - 1)) begin
               cx_in    = XW'(rem_new);
               cy_in    = quo_new;
               dirty_in = 1'b0;
               state_in = grm_pkg::ST_LOAD;
            end
         end

         grm_pkg::ST_LOAD: begin
            state_in = grm_pkg::ST_IDLE;
            if (in_grid) begin
               cell_in = ld_cell + CW'(1);
               if (CLW'(ld_x) + CLW'(1) == cols) begin
                  cx_in = '0;
                  cy_in = ld_y + CW'(1);
               end else begin
                  cx_in = XW'(ld_x + XW'(1));
               end
               if (ld_solid) begin
                  mem_we    = 1'b1;
                  mem_waddr = ld_rc[AW-1:0];
                  wr        = '{x: ld_x, y: YW'(ld_y), w: WW'(1), h: HW'(1),
                                live: 1'b1};
                  rc_in     = ld_rc + CW'(1);
               end
            end
         end

         grm_pkg::ST_I_RD: begin
            mem_re    = 1'b1;
            mem_raddr = i_ff[AW-1:0];
            state_in  = grm_pkg::ST_I_EV;
         end

         grm_pkg::ST_I_EV: begin
            base_in = rd;
            if (rd.live) begin
               j_in     = i_ff + CW'(1);
               state_in = grm_pkg::ST_J_RD;
            end else if (i_more) begin
               i_in     = i_ff + CW'(1);
               state_in = grm_pkg::ST_I_RD;
            end else if (!vert_ff) begin
               vert_in  = 1'b1;
               i_in     = '0;
               state_in = grm_pkg::ST_I_RD;
            end else begin
               i_in     = '0;
               k_in     = '0;
               state_in = grm_pkg::ST_C_RD;
            end
         end

         grm_pkg::ST_J_RD: begin
            mem_re    = 1'b1;
            mem_raddr = j_ff[AW-1:0];
            state_in  = grm_pkg::ST_J_EV;
         end

         grm_pkg::ST_J_EV: begin
            if (rd.live && fu_hit) begin
               base_in.w = fu_w;
               base_in.h = fu_h;
               fused_in  = 1'b1;
               // absorbed rectangle dies in place
               mem_we    = 1'b1;
               mem_waddr = j_ff[AW-1:0];
               wr        = rd;
               wr.live   = 1'b0;
            end
            if (j_more) begin
               j_in     = j_ff + CW'(1);
               state_in = grm_pkg::ST_J_RD;
            end else begin
               state_in = grm_pkg::ST_I_WB;
            end
         end

         grm_pkg::ST_I_WB: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff[AW-1:0];
            wr        = base_ff;
            if (i_more) begin
               i_in     = i_ff + CW'(1);
               state_in = grm_pkg::ST_I_RD;
            end else if (!vert_ff) begin
               vert_in  = 1'b1;
               i_in     = '0;
               state_in = grm_pkg::ST_I_RD;
            end else begin
               i_in     = '0;
               k_in     = '0;
               state_in = grm_pkg::ST_C_RD;
            end
         end

         grm_pkg::ST_C_RD: begin
            mem_re    = 1'b1;
            mem_raddr = i_ff[AW-1:0];
            state_in  = grm_pkg::ST_C_EV;
         end

         grm_pkg::ST_C_EV: begin
            if (rd.live) begin
               mem_we    = 1'b1;
               mem_waddr = k_ff[AW-1:0];
               wr        = rd;
            end
            k_in = k_next;
            if (c_more) begin
               i_in     = i_ff + CW'(1);
               state_in = grm_pkg::ST_C_RD;
            end else begin
               rc_in = k_next;
               if (fused_ff && (k_next > CW'(1))) begin
                  fused_in = 1'b0;
                  vert_in  = 1'b0;
                  i_in     = '0;
                  state_in = grm_pkg::ST_I_RD;
               end else begin
                  md_in    = 1'b1;
                  rp_in    = '0;
                  state_in = grm_pkg::ST_OUT_RD;
               end
            end
         end

         grm_pkg::ST_OUT_RD: begin
            if (rp_ff < rc_ff) begin
               mem_re    = 1'b1;
               mem_raddr = rp_ff[AW-1:0];
               state_in  = grm_pkg::ST_OUT_EV;
            end else begin
               rsp_in           = '0;
               rsp_in.empty_set = 1'b1;
               rsp_strobe_in    = 1'b1;
               state_in         = grm_pkg::ST_IDLE;
            end
         end

         grm_pkg::ST_OUT_EV: begin
            rsp_in.rect_x    = 6'(rd.x);
            rsp_in.rect_y    = 6'(rd.y);
            rsp_in.rect_w    = 7'(rd.w);
            rsp_in.rect_h    = 7'(rd.h);
            rsp_in.last_rect = (rp_ff + CW'(1)) == rc_ff;
            rsp_in.empty_set = 1'b0;
            rsp_strobe_in    = 1'b1;
            rp_in            = rp_ff + CW'(1);
            state_in         = grm_pkg::ST_IDLE;
         end

         default: begin
            state_in = grm_pkg::ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= grm_pkg::ST_IDLE;
         md_ff         <= 1'b0;
         rc_ff         <= '0;
         rp_ff         <= '0;
         cell_ff       <= '0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         dirty_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         md_ff         <= md_in;
         rc_ff         <= rc_in;
         rp_ff         <= rp_in;
         cell_ff       <= cell_in;
         cx_ff         <= cx_in;
         cy_ff         <= cy_in;
         dirty_ff      <= dirty_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      vert_ff  <= vert_in;
      fused_ff <= fused_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      base_ff  <= base_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dcnt_ff  <= dcnt_in;
      solid_ff <= solid_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = state_ff != grm_pkg::ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ----- sv/grid_rectangle_merger_top.sv -----
`timescale 1ns / 1ps
// Grid rectangle merger: top level with grid-shape registers.
//
// Cells arrive in raster order on the request channel: a word is taken when
// start is high and busy is low. action = load stores one cell; a solid cell
// becomes a 1x1 rectangle. action = read returns the next merged rectangle.
// A load partway through a grid after a grid-shape write first runs a
// bit-serial divide of the cell count that recovers the column and row.
// The first read after loading runs merge rounds on the rectangle store:
// each round is a horizontal and a vertical pass, each comparing every live
// pair, followed by a compaction of the live rectangles.
// A read of a stored rectangle goes through the store read, then the output
// register; an empty read goes through the output register alone.
// The result shows for one cycle on rsp_strobe; the receiver cannot stall,
// and the next request is taken while it shows.
// Config writes (csr_*) are always ready and must land while busy is low.
// After reset the grid is 64 x 64 and the store holds nothing; no clearing
// pass is needed.
module grid_rectangle_merger_top #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  grm_pkg::req_type                       req_data,
   output logic                                   rsp_strobe,
   output grm_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [grm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [grm_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = $clog2(MAX_COLS) + $clog2(MAX_ROWS) + $clog2(MAX_COLS + 1)
                          + $clog2(MAX_ROWS + 1) + 1;
   localparam int CLW   = $clog2(MAX_COLS + 1);
   localparam int RLW   = $clog2(MAX_ROWS + 1);

   logic [grm_pkg::CSR_DATA_W-1:0] grid_cols_ff, grid_cols_in;
   logic [grm_pkg::CSR_DATA_W-1:0] grid_rows_ff, grid_rows_in;
   logic                           csr_wr;
   logic [CLW-1:0]                 cols;
   logic [RLW-1:0]                 rows;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [EW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [EW-1:0] mem_rdata;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      if (csr_wr) begin
         unique case (csr_index)
            grm_pkg::CSR_GRID_COLS: grid_cols_in = csr_wdata;
            grm_pkg::CSR_GRID_ROWS: grid_rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= grm_pkg::GRID_DIM_RESET;
         grid_rows_ff <= grm_pkg::GRID_DIM_RESET;
      end else begin
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
      end
   end

   // zero counts as one, anything past the maximum as the maximum
   always_comb begin
      if (grid_cols_ff == '0) begin
         cols = CLW'(1);
      end else if (32'(grid_cols_ff) > 32'(MAX_COLS)) begin
         cols = CLW'(MAX_COLS);
      end else begin
         cols = CLW'(grid_cols_ff);
      end
      if (grid_rows_ff == '0) begin
         rows = RLW'(1);
      end else if (32'(grid_rows_ff) > 32'(MAX_ROWS)) begin
         rows = RLW'(MAX_ROWS);
      end else begin
         rows = RLW'(grid_rows_ff);
      end
   end

   grm_rect_mem #(
      .DEPTH  (DEPTH),
      .DATA_W (EW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   grm_ctrl #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_data),
      .busy       (busy),
      .cols       (cols),
      .rows       (rows),
      .cfg_wr     (csr_wr),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

endmodule

// ----- sv/grm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the grid rectangle merger, bound to the top level.
module grm_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input grm_pkg::req_type req_data,
   input logic             rsp_strobe,
   input grm_pkg::rsp_type rsp_data
);

   // a read always makes the block busy in the cycle after it is taken
   a_read_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.action == grm_pkg::ACT_READ) |=> busy)
      else $error("read accepted without going busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without preceding work");

   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result words back to back");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.action == grm_pkg::ACT_LOAD) |=> !rsp_strobe)
      else $error("load produced a result word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe && !rsp_data.last_rect | !rsp_strobe)
      else $error("activity right after reset");

endmodule

bind grid_rectangle_merger_top grm_checker u_grm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- tb/sv/tb_grid_rectangle_merger_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the grid rectangle merger: directed table, then random grids.
module tb_grid_rectangle_merger_top;

   localparam int GRID_LIM    = 64;
   localparam int STORE_LIM   = GRID_LIM * GRID_LIM;
   localparam int DIV_SLACK   = 24;        // covers the divide after a grid-shape write
   localparam int STALL_LIMIT = 1000000;   // well above a full merge of 64 cells
   localparam int PHASE_WORDS = 550;
   localparam int REPORT_MAX  = 10;
   localparam int PLAN_MAX    = 64;
   localparam int DUE_DEPTH   = 16;

   localparam grm_pkg::rsp_type NO_RECT =
      grm_pkg::rsp_type'({6'd0, 6'd0, 7'd0, 7'd0, 1'b0, 1'b1});

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                         kind;
      grm_pkg::req_type                     word;
      logic [grm_pkg::CSR_IDX_W-1:0]        idx;
      logic [grm_pkg::CSR_DATA_W-1:0]       val;
      bit                                   typed;
      grm_pkg::rsp_type                     want;
   } plan_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   grm_pkg::req_type                     req_data = '0;
   logic                                 rsp_strobe;
   grm_pkg::rsp_type                     rsp_data;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [grm_pkg::CSR_IDX_W-1:0]        csr_index = '0;
   logic [grm_pkg::CSR_DATA_W-1:0]       csr_wdata = '0;

   // shadow of the block's state
   logic [grm_pkg::CSR_DATA_W-1:0]       cols_reg = grm_pkg::GRID_DIM_RESET;
   logic [grm_pkg::CSR_DATA_W-1:0]       rows_reg = grm_pkg::GRID_DIM_RESET;
   int unsigned               box_x [STORE_LIM];
   int unsigned               box_y [STORE_LIM];
   int unsigned               box_w [STORE_LIM];
   int unsigned               box_h [STORE_LIM];
   bit                        box_live [STORE_LIM];
   int unsigned               cells_in = 0;
   int unsigned               boxes = 0;
   int unsigned               out_ptr = 0;
   bit                        merged = 1'b0;

   // expected result words, in order
   grm_pkg::rsp_type          due_ring [DUE_DEPTH];
   int unsigned               due_head = 0;
   int unsigned               due_tail = 0;
   grm_pkg::rsp_type          last_rsp;
   grm_pkg::rsp_type          due_rect;
   plan_row_type              plan [PLAN_MAX];
   int unsigned               plan_len = 0;
   int unsigned               mismatches = 0;
   int unsigned               stall_cycles = 0;
   int unsigned               words_sent = 0;
   int unsigned               idle_pct = 0;

   grid_rectangle_merger_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned fit_dim(input logic [grm_pkg::CSR_DATA_W-1:0] v,
                                           input int unsigned hi);
      if (v == 0) return 1;
      if (32'(v) > hi) return hi;
      return 32'(v);
   endfunction

   // one fuse pass over the live boxes; vert selects the column/width/bottom-edge rule
   function automatic bit fuse_boxes(input bit vert);
      bit any;
      int unsigned i, j;
      any = 1'b0;
      for (i = 0; i + 1 < boxes; i++) begin
         if (!box_live[i]) continue;
         for (j = i + 1; j < boxes; j++) begin
            if (!box_live[j]) continue;
            if (!vert && box_y[i] == box_y[j] && box_h[i] == box_h[j] &&
                box_x[i] + box_w[i] == box_x[j]) begin
               box_w[i] += box_w[j];
               box_live[j] = 1'b0;
               any = 1'b1;
            end else if (vert && box_x[i] == box_x[j] && box_w[i] == box_w[j] &&
                         box_y[i] + box_h[i] == box_y[j]) begin
               box_h[i] += box_h[j];
               box_live[j] = 1'b0;
               any = 1'b1;
            end
         end
      end
      return any;
   endfunction

   function automatic void predict_rect(input grm_pkg::req_type w, output bit has,
                                        output grm_pkg::rsp_type r);
      int unsigned cols, rows, p, k;
      bit fused, h_fused, v_fused;
      has = 1'b0;
      r = '0;
      if (w.action == grm_pkg::ACT_LOAD) begin
         cols = fit_dim(cols_reg, GRID_LIM);
         rows = fit_dim(rows_reg, GRID_LIM);
         if (merged) begin
            cells_in = 0;
            boxes = 0;
            out_ptr = 0;
            merged = 1'b0;
         end
         if (cells_in < cols * rows) begin
            if (w.solid && boxes < STORE_LIM) begin
               box_x[boxes] = cells_in % cols;
               box_y[boxes] = cells_in / cols;
               box_w[boxes] = 1;
               box_h[boxes] = 1;
               box_live[boxes] = 1'b1;
               boxes++;
            end
            cells_in++;
         end
      end else begin
         if (!merged) begin
            fused = 1'b1;
            while (fused && boxes > 1) begin
               h_fused = fuse_boxes(1'b0);
               v_fused = fuse_boxes(1'b1);
               fused = h_fused || v_fused;
               k = 0;
               for (p = 0; p < boxes; p++) begin
                  if (box_live[p]) begin
                     box_x[k] = box_x[p];
                     box_y[k] = box_y[p];
                     box_w[k] = box_w[p];
                     box_h[k] = box_h[p];
                     box_live[k] = 1'b1;
                     k++;
                  end
               end
               boxes = k;
            end
            merged = 1'b1;
            out_ptr = 0;
         end
         has = 1'b1;
         if (out_ptr < boxes) begin
            r.rect_x = 6'(box_x[out_ptr]);
            r.rect_y = 6'(box_y[out_ptr]);
            r.rect_w = 7'(box_w[out_ptr]);
            r.rect_h = 7'(box_h[out_ptr]);
            r.last_rect = (out_ptr + 1 == boxes);
            out_ptr++;
         end else begin
            r.empty_set = 1'b1;
         end
      end
   endfunction

   function automatic void plan_add(input plan_row_type row);
      plan[plan_len] = row;
      plan_len++;
   endfunction

   function automatic void plan_word(input logic action, input logic solid);
      plan_row_type row;
      row = '{ROW_WORD, grm_pkg::req_type'({action, solid}), '0, '0, 1'b0, NO_RECT};
      plan_add(row);
   endfunction

   // read whose result is typed in
   function automatic void plan_check(input grm_pkg::rsp_type want);
      plan_row_type row;
      row = '{ROW_WORD, grm_pkg::req_type'({grm_pkg::ACT_READ, 1'b0}), '0, '0, 1'b1, want};
      plan_add(row);
   endfunction

   function automatic void plan_csr(input logic [grm_pkg::CSR_IDX_W-1:0] idx,
                                    input logic [grm_pkg::CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = '{ROW_CSR, grm_pkg::req_type'(2'b00), idx, val, 1'b0, NO_RECT};
      plan_add(row);
   endfunction

   function automatic void note_error(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("ERROR: %s", what);
   endfunction

   task automatic drive_word(input grm_pkg::req_type w, input bit typed,
                             input grm_pkg::rsp_type want);
      bit has;
      grm_pkg::rsp_type r;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      words_sent++;
      predict_rect(w, has, r);
      if (has) begin
         due_ring[due_tail % DUE_DEPTH] = typed ? want : r;
         due_tail++;
         last_rsp = r;
      end
   endtask

   task automatic write_reg(input logic [grm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [grm_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == grm_pkg::CSR_GRID_COLS) cols_reg = val;
      else rows_reg = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain: every result in, then time for a trailing divide to finish
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (due_tail != due_head);
      repeat (DIV_SLACK) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic run_grid();
      int unsigned shape, density, cells, loads, n, pick;
      logic [grm_pkg::CSR_DATA_W-1:0] cols_v, rows_v;
      bit mid_change, extra;
      grm_pkg::req_type w;
      shape = $urandom_range(99);
      if (shape < 7) begin
         // single wide row
         cols_v = $urandom_range(1) ? 7'd64 : 7'($urandom_range(127, 65));
         rows_v = 7'($urandom_range(1));
      end else if (shape < 14) begin
         // single tall column
         cols_v = 7'($urandom_range(1));
         rows_v = $urandom_range(1) ? 7'd64 : 7'($urandom_range(127, 65));
      end else begin
         cols_v = 7'($urandom_range(8));
         rows_v = 7'($urandom_range(8));
      end
      pick = $urandom_range(7);
      density = (pick < 3) ? 100 : (pick < 5) ? 85 : (pick < 7) ? 50 : 10;
      settle();
      write_reg(grm_pkg::CSR_GRID_COLS, cols_v);
      write_reg(grm_pkg::CSR_GRID_ROWS, rows_v);
      cells = fit_dim(cols_v, GRID_LIM) * fit_dim(rows_v, GRID_LIM);
      pick = $urandom_range(9);
      loads = (pick == 0) ? $urandom_range(cells - 1) :
              (pick == 1) ? cells + $urandom_range(3, 1) : cells;
      mid_change = (shape >= 14) && ($urandom_range(9) == 0);
      for (n = 0; n < loads; n++) begin
         if (mid_change && n == loads / 2) begin
            settle();
            write_reg(grm_pkg::CSR_GRID_COLS, 7'($urandom_range(8, 1)));
         end
         if ($urandom_range(99) < 6) begin
            w = grm_pkg::req_type'(2'($urandom_range(3)));
         end else begin
            w.action = grm_pkg::ACT_LOAD;
            w.solid = ($urandom_range(99) < density);
         end
         drive_word(w, 1'b0, NO_RECT);
      end
      // read the set out; sometimes go on until the empty marker
      extra = 1'($urandom_range(1));
      do begin
         w.action = grm_pkg::ACT_READ;
         w.solid = 1'($urandom_range(1));
         drive_word(w, 1'b0, NO_RECT);
      end while (!last_rsp.empty_set && (extra || !last_rsp.last_rect));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (due_tail == due_head) begin
            note_error($sformatf("unexpected result word x=%0d y=%0d w=%0d h=%0d",
                                 rsp_data.rect_x, rsp_data.rect_y,
                                 rsp_data.rect_w, rsp_data.rect_h));
         end else begin
            due_rect = due_ring[due_head % DUE_DEPTH];
            due_head++;
            if (rsp_data.rect_x !== due_rect.rect_x || rsp_data.rect_y !== due_rect.rect_y ||
                rsp_data.rect_w !== due_rect.rect_w || rsp_data.rect_h !== due_rect.rect_h ||
                rsp_data.last_rect !== due_rect.last_rect ||
                rsp_data.empty_set !== due_rect.empty_set) begin
               note_error($sformatf({"rect mismatch: exp x=%0d y=%0d w=%0d h=%0d last=%0b ",
                                     "empty=%0b, got x=%0d y=%0d w=%0d h=%0d last=%0b empty=%0b"},
                                    due_rect.rect_x, due_rect.rect_y, due_rect.rect_w,
                                    due_rect.rect_h, due_rect.last_rect, due_rect.empty_set,
                                    rsp_data.rect_x, rsp_data.rect_y, rsp_data.rect_w,
                                    rsp_data.rect_h, rsp_data.last_rect, rsp_data.empty_set));
            end
         end
      end
   end

   // watchdog: cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned phase, mark, plan_idx;
      plan_row_type row;

      // empty store straight after reset
      plan_check(NO_RECT);
      // partial 64 x 64 grid, read before it is full
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_word(grm_pkg::ACT_LOAD, 1'b0);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_word(grm_pkg::ACT_READ, 1'b0);
      plan_word(grm_pkg::ACT_READ, 1'b1);
      plan_check(NO_RECT);
      // zero column count runs as one; third cell falls off the grid
      plan_csr(grm_pkg::CSR_GRID_COLS, 7'd0);
      plan_csr(grm_pkg::CSR_GRID_ROWS, 7'd2);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_check(grm_pkg::rsp_type'({6'd0, 6'd0, 7'd1, 7'd2, 1'b1, 1'b0}));
      // single rectangle
      plan_csr(grm_pkg::CSR_GRID_COLS, 7'd1);
      plan_csr(grm_pkg::CSR_GRID_ROWS, 7'd1);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_check(grm_pkg::rsp_type'({6'd0, 6'd0, 7'd1, 7'd1, 1'b1, 1'b0}));
      plan_check(NO_RECT);
      // oversize row count, column count changed partway through the grid
      plan_csr(grm_pkg::CSR_GRID_COLS, 7'd2);
      plan_csr(grm_pkg::CSR_GRID_ROWS, 7'd127);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_csr(grm_pkg::CSR_GRID_COLS, 7'd3);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_word(grm_pkg::ACT_LOAD, 1'b0);
      plan_word(grm_pkg::ACT_LOAD, 1'b1);
      plan_word(grm_pkg::ACT_READ, 1'b0);
      plan_word(grm_pkg::ACT_READ, 1'b1);
      plan_word(grm_pkg::ACT_READ, 1'b0);
      plan_word(grm_pkg::ACT_READ, 1'b1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 10;
      for (plan_idx = 0; plan_idx < plan_len; plan_idx++) begin
         row = plan[plan_idx];
         if (row.kind == ROW_CSR) begin
            settle();
            write_reg(row.idx, row.val);
         end else begin
            drive_word(row.word, row.typed, row.want);
         end
      end

      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 10 : (phase == 1) ? 46 : 0;
         mark = words_sent;
         while (words_sent - mark < PHASE_WORDS) run_grid();
      end

      settle();
      if (mismatches == 0 && due_tail == due_head) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
